>>> rtl/core/tsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types, register codes and alpha tables for the texel stream decoder.
// ----------------------------------------------------------------------------
package tsd_pkg;

  // Default depth of the job queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // Configuration port widths.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  // Texture encodings as programmed in the format register.
  typedef enum logic [2:0] {
    FMT_PAL2   = 3'd0,
    FMT_PAL4   = 3'd1,
    FMT_PAL8   = 3'd2,
    FMT_PASS3  = 3'd3,
    FMT_A5I3   = 3'd4,
    FMT_DIRECT = 3'd5,
    FMT_A3I5   = 3'd6,
    FMT_PASS7  = 3'd7
  } fmt_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORMAT = 1'b0,
    REG_OPAQUE = 1'b1
  } reg_idx_t;

  // How the back end expands one queued job into texels.
  typedef enum logic [2:0] {
    MODE_PAL2,
    MODE_PAL4,
    MODE_PAL8,
    MODE_A5I3,
    MODE_A3I5,
    MODE_DIRECT,
    MODE_PASS
  } mode_t;

  // One classified job: a byte (or a paired 16-bit color) and the index of its final texel.
  typedef struct packed {
    mode_t       mode;
    logic [15:0] data;
    logic [1:0]  last_k;   // index of the final texel of this job
    logic        opaque;
    logic        last;
  } job_t;

  // 5-bit alpha scaled to 0..255, rounded to nearest.
  localparam logic [7:0] ALPHA5_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
    8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
    8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
    8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
  };

  // 3-bit alpha scaled to 0..255, rounded to nearest.
  localparam logic [7:0] ALPHA3_LUT [8] = '{
    8'd0, 8'd36, 8'd73, 8'd109, 8'd146, 8'd182, 8'd219, 8'd255
  };

endpackage

>>> rtl/core/tsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_front
// Holds the configuration registers, accepts encoded bytes, pairs direct-color
// bytes and pushes one classified job per texel-producing byte.
// ----------------------------------------------------------------------------
module tsd_front
  import tsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Byte stream
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  // Job queue push side
  output logic                  job_valid,
  input  logic                  job_ready,
  output job_t                  job
);

  fmt_t       fmt_r;
  logic       opaque_r;
  logic       pair_phase_r;
  logic [7:0] held_r;
  logic       accept;
  logic       low_half;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // A byte is taken whenever the queue has room.
  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;

  // A direct-color low byte only fills the holding register.
  assign low_half  = (fmt_r == FMT_DIRECT) && !pair_phase_r;
  assign job_valid = in_valid && !low_half;

  // Classify the byte into a job for the back end.
  always_comb begin
    job.mode   = MODE_PASS;
    job.data   = {8'h00, in_data_byte};
    job.last_k = 2'd0;
    job.opaque = opaque_r;
    job.last   = in_last_byte;
    unique case (fmt_r)
      FMT_PAL2: begin
        job.mode   = MODE_PAL2;
        job.last_k = 2'd3;
      end
      FMT_PAL4: begin
        job.mode   = MODE_PAL4;
        job.last_k = 2'd1;
      end
      FMT_PAL8:   job.mode = MODE_PAL8;
      FMT_A5I3:   job.mode = MODE_A5I3;
      FMT_A3I5:   job.mode = MODE_A3I5;
      FMT_DIRECT: begin
        job.mode = MODE_DIRECT;
        job.data = {in_data_byte, held_r};
      end
      FMT_PASS3, FMT_PASS7: job.mode = MODE_PASS;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_PAL8;
      opaque_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FORMAT: fmt_r    <= fmt_t'(cfg_data[2:0]);
        REG_OPAQUE: opaque_r <= cfg_data[0];
      endcase
    end
  end

  // Direct-color pairing state; a last byte always ends a pair.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_phase_r <= 1'b0;
      held_r       <= 8'h00;
    end else if (accept) begin
      if (low_half) begin
        held_r       <= in_data_byte;
        pair_phase_r <= !in_last_byte;
      end else if ((fmt_r == FMT_DIRECT) || in_last_byte) begin
        pair_phase_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/core/tsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_queue
// Small job queue that decouples the byte front end from the texel back end.
// ----------------------------------------------------------------------------
module tsd_queue
  import tsd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF   // at least 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = mem_r[rd_ptr_r];

  // Storage is written only on a push.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("job queue count beyond depth");

  // A lone push raises the count by exactly one.
  a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("job queue count not advanced on push");

endmodule

>>> rtl/core/tsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_back
// Expands the job at the queue head into texels, one per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module tsd_back
  import tsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Job queue pop side
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  // Texel stream
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_texel_value,
  output logic [7:0]  out_texel_alpha,
  output logic        out_last_texel
);

  logic [1:0]  k_r;
  logic        out_valid_r;
  logic [15:0] value_r;
  logic [7:0]  alpha_r;
  logic        last_r;
  logic        issue;
  logic        final_k;
  logic [7:0]  sel2;
  logic [7:0]  sel4;
  logic [15:0] value_nxt;
  logic [7:0]  alpha_nxt;

  // A texel issues whenever the output stage is empty or draining.
  assign issue     = job_valid && (!out_valid_r || out_ready);
  assign final_k   = (k_r == job.last_k);
  assign job_ready = issue && final_k;

  assign sel2 = job.data[7:0] >> {k_r, 1'b0};
  assign sel4 = job.data[7:0] >> {k_r[0], 2'b00};

  // Texel value and alpha for the current slot of the head job.
  always_comb begin
    value_nxt = {8'h00, job.data[7:0]};
    alpha_nxt = 8'hff;
    unique case (job.mode)
      MODE_PAL2: value_nxt = {14'h0000, sel2[1:0]};
      MODE_PAL4: value_nxt = {12'h000, sel4[3:0]};
      MODE_PAL8: value_nxt = {8'h00, job.data[7:0]};
      MODE_A5I3: begin
        value_nxt = {13'h0000, job.data[2:0]};
        alpha_nxt = ALPHA5_LUT[job.data[7:3]];
      end
      MODE_A3I5: begin
        value_nxt = {11'h000, job.data[4:0]};
        alpha_nxt = ALPHA3_LUT[job.data[7:5]];
      end
      MODE_DIRECT: begin
        value_nxt = job.data;
        alpha_nxt = job.data[15] ? 8'hff : 8'h00;
      end
      MODE_PASS: value_nxt = {8'h00, job.data[7:0]};
      default:   value_nxt = {8'h00, job.data[7:0]};
    endcase
    // Palette index zero is transparent unless the opaque flag is set.
    if ((job.mode == MODE_PAL2 || job.mode == MODE_PAL4 || job.mode == MODE_PAL8)
        && !job.opaque && value_nxt == 16'h0000) begin
      alpha_nxt = 8'h00;
    end
  end

  // Slot counter within the head job.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 2'd0;
    end else if (issue) begin
      k_r <= final_k ? 2'd0 : k_r + 2'd1;
    end
  end

  // Output stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (issue) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output stage payload.
  always_ff @(posedge clk) begin
    if (issue) begin
      value_r <= value_nxt;
      alpha_r <= alpha_nxt;
      last_r  <= job.last && final_k;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_texel_value = value_r;
  assign out_texel_alpha = alpha_r;
  assign out_last_texel  = last_r;

  // The slot counter stays within the head job's texel count.
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> k_r <= job.last_k)
    else $error("texel slot beyond job count");

  // Single-texel jobs always issue from slot zero.
  a_single_slot: assert property (@(posedge clk) disable iff (!rst_n)
    issue && job.last_k == 2'd0 |-> k_r == 2'd0)
    else $error("single-texel job issued from nonzero slot");

endmodule

>>> rtl/core/texel_stream_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_stream_decode
// Decodes an encoded texture byte stream into texels with value and alpha.
// ----------------------------------------------------------------------------
//  Channel | Ports                                         | Direction
//  --------+-----------------------------------------------+----------
//  cfg     | cfg_valid/ready, cfg_index, cfg_data          | in
//  in      | in_valid/ready, in_data_byte, in_last_byte    | in
//  out     | out_valid/ready, out_texel_value/alpha, _last | out
//
// The back end issues one texel per cycle while its output stage is not
// stalled, so a byte yields four texels in 2bpp, two in 4bpp and one in
// every other format; a direct-color texel needs two bytes. The front takes
// a byte each cycle while the job queue has room. The first texel of a byte
// passes through the job queue and then the registered output stage.
// Reset is synchronous and returns the format to 8bpp and clears pairing.
// Either side may stall without losing a transaction.
// ----------------------------------------------------------------------------
module texel_stream_decode
  import tsd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [15:0]           out_texel_value,
  output logic [7:0]            out_texel_alpha,
  output logic                  out_last_texel
);

  logic push_valid;
  logic push_ready;
  job_t push_job;
  logic pop_valid;
  logic pop_ready;
  job_t pop_job;

  // Byte intake and classification.
  tsd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .job_valid    (push_valid),
    .job_ready    (push_ready),
    .job          (push_job)
  );

  // Job queue between the two halves.
  tsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Texel expansion and output stage.
  tsd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (pop_valid),
    .job_ready       (pop_ready),
    .job             (pop_job),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_texel_value (out_texel_value),
    .out_texel_alpha (out_texel_alpha),
    .out_last_texel  (out_last_texel)
  );

endmodule
